// ===== design/djs_pkg.sv =====
// ----------------------------------------------------------------------------
// djs_pkg
// Shared types and constants for the duplicate-refusing job stack.
// ----------------------------------------------------------------------------
package djs_pkg;

  localparam int unsigned JOB_ID_W  = 6;
  localparam int unsigned JOB_SPACE = 1 << JOB_ID_W;
  localparam int unsigned LEVEL_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 8;

  localparam logic [LEVEL_W-1:0] COUNT_MAX     = 8'd255;
  localparam logic [CFG_W-1:0]   LIMIT_RESET   = 8'd10;
  localparam logic [CFG_W-1:0]   WINDOW_RESET  = 8'd5;

  typedef enum logic [1:0] {
    MODE_POST = 2'd0,
    MODE_TAKE = 2'd1,
    MODE_TICK = 2'd2,
    MODE_RSVD = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OVERLOAD_LIMIT = 2'd0,
    CFG_QUIET_WINDOW   = 2'd1,
    CFG_UNUSED2        = 2'd2,
    CFG_UNUSED3        = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_EXEC  = 2'd2
  } state_e;

  typedef struct packed {
    logic reject;
    logic tick;
  } watch_evt_t;

  typedef struct packed {
    logic               fatal;
    logic               fatal_next;
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] level_next;
  } watch_stat_t;

endpackage

// ===== design/djs_ram.sv =====
// ----------------------------------------------------------------------------
// djs_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module djs_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 6
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/djs_watch.sv =====
// ----------------------------------------------------------------------------
// djs_watch
// Overload counter, quiet-window aging, sticky fatal flag and config regs.
// ----------------------------------------------------------------------------
module djs_watch
  import djs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  watch_evt_t           evt_i,
  output watch_stat_t          stat_o
);

  logic [CFG_W-1:0]   limit_q, window_q;
  logic [LEVEL_W-1:0] cnt_q, cnt_d, last_q, last_d, age_q, age_d;
  logic [LEVEL_W-1:0] cnt_inc, age_inc;
  logic               fatal_q, fatal_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= LIMIT_RESET;
      window_q <= WINDOW_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_OVERLOAD_LIMIT: limit_q  <= cfg_data_i;
        CFG_QUIET_WINDOW:   window_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cnt_d   = cnt_q;
    last_d  = last_q;
    age_d   = age_q;
    fatal_d = fatal_q;
    cnt_inc = (cnt_q != COUNT_MAX) ? cnt_q + LEVEL_W'(1) : cnt_q;
    age_inc = (age_q != COUNT_MAX) ? age_q + LEVEL_W'(1) : age_q;
    if (evt_i.reject) begin
      cnt_d = cnt_inc;
      if (cnt_inc > limit_q) begin
        fatal_d = 1'b1;
      end
    end else if (evt_i.tick && cnt_q != '0) begin
      if (last_q != cnt_q) begin
        last_d = cnt_q;
        age_d  = '0;
      end else if (age_inc > window_q) begin
        cnt_d  = '0;
        last_d = '0;
        age_d  = '0;
      end else begin
        age_d = age_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      last_q  <= '0;
      age_q   <= '0;
      fatal_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      last_q  <= last_d;
      age_q   <= age_d;
      fatal_q <= fatal_d;
    end
  end

  assign stat_o.fatal      = fatal_q;
  assign stat_o.fatal_next = fatal_d;
  assign stat_o.level      = cnt_q;
  assign stat_o.level_next = cnt_d;

endmodule

// ===== design/djs_ctrl.sv =====
// ----------------------------------------------------------------------------
// djs_ctrl
// Request sequencer: pending-bit and stack memories, read-modify-write,
// stack pointer and result register.
// ----------------------------------------------------------------------------
module djs_ctrl
  import djs_pkg::*;
#(
  parameter int unsigned JOB_COUNT = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          mode_i,
  input  logic [JOB_ID_W-1:0] job_id_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                accepted_o,
  output logic                rejected_busy_o,
  output logic                fatal_o,
  output logic                popped_valid_o,
  output logic [JOB_ID_W-1:0] popped_job_o,
  output logic [LEVEL_W-1:0]  overload_level_o,
  output watch_evt_t          evt_o,
  input  watch_stat_t         stat_i
);

  localparam int unsigned Depth = (JOB_COUNT < JOB_SPACE) ? JOB_COUNT : JOB_SPACE;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned FillW = $clog2(Depth + 1);
  localparam logic [JOB_ID_W:0] JobLimit = (JOB_ID_W + 1)'(Depth);
  localparam logic [AddrW-1:0]  LastAddr = AddrW'(Depth - 1);
  localparam logic [FillW-1:0]  FillFull = FillW'(Depth);

  state_e              state_q, state_d;
  mode_e               mode_q, mode_d;
  logic [JOB_ID_W-1:0] job_q, job_d;
  logic [FillW-1:0]    fill_q, fill_d;
  logic [AddrW-1:0]    clr_q, clr_d;

  logic                out_valid_q, out_valid_d;
  logic                acc_q, acc_d, rej_q, rej_d, fatal_q, fatal_d, pv_q, pv_d;
  logic [JOB_ID_W-1:0] pj_q, pj_d;
  logic [LEVEL_W-1:0]  lvl_q, lvl_d;

  logic                pend_we, pend_re;
  logic [AddrW-1:0]    pend_waddr, pend_raddr;
  logic [0:0]          pend_wdata, pend_rdata;
  logic                stk_we, stk_re;
  logic [AddrW-1:0]    stk_waddr, stk_raddr;
  logic [JOB_ID_W-1:0] stk_rdata;

  logic                in_fire, slot_free, in_range;

  djs_ram #(.DEPTH(Depth), .WIDTH(1)) u_pend_ram (
    .clk_i   (clk_i),
    .we_i    (pend_we),
    .waddr_i (pend_waddr),
    .wdata_i (pend_wdata),
    .re_i    (pend_re),
    .raddr_i (pend_raddr),
    .rdata_o (pend_rdata)
  );

  djs_ram #(.DEPTH(Depth), .WIDTH(JOB_ID_W)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (job_q),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_range   = {1'b0, job_q} < JobLimit;

  assign pend_re    = in_fire;
  assign pend_raddr = job_id_i[AddrW-1:0];
  assign stk_re     = in_fire;
  assign stk_raddr  = AddrW'(fill_q - FillW'(1));
  assign stk_waddr  = fill_q[AddrW-1:0];

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    job_d       = job_q;
    fill_d      = fill_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    acc_d       = acc_q;
    rej_d       = rej_q;
    fatal_d     = fatal_q;
    pv_d        = pv_q;
    pj_d        = pj_q;
    lvl_d       = lvl_q;
    pend_we     = 1'b0;
    pend_waddr  = clr_q;
    pend_wdata  = 1'b0;
    stk_we      = 1'b0;
    evt_o       = '0;

    unique case (state_q)
      ST_CLEAR: begin
        pend_we = 1'b1;
        clr_d   = clr_q + AddrW'(1);
        if (clr_q == LastAddr) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          mode_d  = mode_e'(mode_i);
          job_d   = job_id_i;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (slot_free) begin
          acc_d = 1'b0;
          rej_d = 1'b0;
          pv_d  = 1'b0;
          pj_d  = '0;
          if (!stat_i.fatal) begin
            unique case (mode_q)
              MODE_POST: begin
                if (in_range) begin
                  if (pend_rdata[0]) begin
                    evt_o.reject = 1'b1;
                    rej_d        = 1'b1;
                  end else if (fill_q < FillFull) begin
                    pend_we    = 1'b1;
                    pend_waddr = job_q[AddrW-1:0];
                    pend_wdata = 1'b1;
                    stk_we     = 1'b1;
                    fill_d     = fill_q + FillW'(1);
                    acc_d      = 1'b1;
                  end
                end
              end
              MODE_TAKE: begin
                if (fill_q != '0) begin
                  pend_we    = 1'b1;
                  pend_waddr = stk_rdata[AddrW-1:0];
                  pend_wdata = 1'b0;
                  fill_d     = fill_q - FillW'(1);
                  pv_d       = 1'b1;
                  pj_d       = stk_rdata;
                end
              end
              MODE_TICK: evt_o.tick = 1'b1;
              default: ;
            endcase
          end
          fatal_d     = stat_i.fatal_next;
          lvl_d       = stat_i.level_next;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      fill_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    job_q   <= job_d;
    acc_q   <= acc_d;
    rej_q   <= rej_d;
    fatal_q <= fatal_d;
    pv_q    <= pv_d;
    pj_q    <= pj_d;
    lvl_q   <= lvl_d;
  end

  assign out_valid_o      = out_valid_q;
  assign accepted_o       = acc_q;
  assign rejected_busy_o  = rej_q;
  assign fatal_o          = fatal_q;
  assign popped_valid_o   = pv_q;
  assign popped_job_o     = pj_q;
  assign overload_level_o = lvl_q;

endmodule

// ===== design/dedup_job_stack_with_overload_watch_unit.sv =====
// ----------------------------------------------------------------------------
// dedup_job_stack_with_overload_watch_unit
// LIFO job stack that refuses duplicate posts, with overload watchdog.
// ----------------------------------------------------------------------------
// Per request (post, take or tick), the pending-bit and
// stack memories are read on acceptance and written back, with the result
// registered, in the execute state, which waits until the held result is taken.
// One result per request; the next request is taken while a result waits.
// After reset a clearing pass zeroes all min(JOB_COUNT, 64) pending-bit
// entries, during which no request is taken; config writes are always
// taken and must only be issued while the block is idle.
module dedup_job_stack_with_overload_watch_unit
  import djs_pkg::*;
#(
  parameter int unsigned JOB_COUNT = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           mode_i,
  input  logic [JOB_ID_W-1:0]  job_id_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 accepted_o,
  output logic                 rejected_busy_o,
  output logic                 fatal_o,
  output logic                 popped_valid_o,
  output logic [JOB_ID_W-1:0]  popped_job_o,
  output logic [LEVEL_W-1:0]   overload_level_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  watch_evt_t  evt;
  watch_stat_t stat;

  assign cfg_ready_o = 1'b1;

  djs_watch u_watch (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .evt_i       (evt),
    .stat_o      (stat)
  );

  djs_ctrl #(.JOB_COUNT(JOB_COUNT)) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .mode_i           (mode_i),
    .job_id_i         (job_id_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .accepted_o       (accepted_o),
    .rejected_busy_o  (rejected_busy_o),
    .fatal_o          (fatal_o),
    .popped_valid_o   (popped_valid_o),
    .popped_job_o     (popped_job_o),
    .overload_level_o (overload_level_o),
    .evt_o            (evt),
    .stat_i           (stat)
  );

endmodule

// ===== design/djs_checker.sv =====
// ----------------------------------------------------------------------------
// djs_checker
// Port-level checks for the job stack, bound to the top level.
// ----------------------------------------------------------------------------
module djs_checker
  import djs_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic                accepted_o,
  input logic                rejected_busy_o,
  input logic                fatal_o,
  input logic                popped_valid_o,
  input logic [JOB_ID_W-1:0] popped_job_o,
  input logic [LEVEL_W-1:0]  overload_level_o
);

  logic seen_fatal_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_fatal_q <= 1'b0;
    end else if (out_valid_o && out_ready_i && fatal_o) begin
      seen_fatal_q <= 1'b1;
    end
  end

  a_fatal_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && seen_fatal_q |-> fatal_o && !accepted_o && !popped_valid_o)
    else $error("fatal flag dropped or request processed after fatal");

  a_acc_rej_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(accepted_o && rejected_busy_o) && !(popped_valid_o && accepted_o))
    else $error("conflicting result flags");

  a_pop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !popped_valid_o |-> popped_job_o == '0)
    else $error("popped job nonzero without pop");

  a_reject_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rejected_busy_o |-> overload_level_o != '0)
    else $error("reject without overload count");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(popped_job_o)
      && $stable(overload_level_o))
    else $error("result changed while stalled");

endmodule

bind dedup_job_stack_with_overload_watch_unit djs_checker u_djs_checker (.*);

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the duplicate-refusing job stack with overload watch.
// A request queue feeds a clocked driver with random gaps. A clocked monitor
// stalls at random and checks each result against outcomes predicted when the
// request was queued. Config writes happen only between phases, once every
// result has drained. The last phase runs the overload count up to the fatal
// latch and then checks that the block stays frozen.
// ----------------------------------------------------------------------------
module tb;
  import djs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT  = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AT     = 120;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    mode_e               mode;
    logic [JOB_ID_W-1:0] job;
  } request_t;

  typedef struct packed {
    logic                accepted;
    logic                rejected;
    logic                fatal;
    logic                popped;
    logic [JOB_ID_W-1:0] job;
    logic [LEVEL_W-1:0]  level;
  } outcome_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_mode = MODE_POST;
  logic [JOB_ID_W-1:0]  in_job = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 accepted_o, rejected_busy_o, fatal_o, popped_valid_o;
  logic [JOB_ID_W-1:0]  popped_job_o;
  logic [LEVEL_W-1:0]   overload_level_o;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_OVERLOAD_LIMIT;
  logic [CFG_W-1:0]     cfg_data = '0;

  request_t job_requests[$];
  outcome_t due_outcomes[$];

  int gap_max   = 8;
  int stall_max = 8;
  int mismatches = 0;

  // predicted block state
  logic                m_pend[JOB_SPACE];
  logic [JOB_ID_W-1:0] m_stack[JOB_SPACE];
  int                  m_fill;
  logic [LEVEL_W-1:0]  m_count, m_last, m_age;
  logic                m_fatal;
  logic [CFG_W-1:0]    m_limit, m_window;

  dedup_job_stack_with_overload_watch_unit DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .mode_i           (in_mode),
    .job_id_i         (in_job),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .accepted_o       (accepted_o),
    .rejected_busy_o  (rejected_busy_o),
    .fatal_o          (fatal_o),
    .popped_valid_o   (popped_valid_o),
    .popped_job_o     (popped_job_o),
    .overload_level_o (overload_level_o),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic outcome_t predict_outcome(mode_e mode, logic [JOB_ID_W-1:0] job);
    outcome_t o;
    o = '0;
    if (!m_fatal) begin
      case (mode)
        MODE_POST: begin
          if (m_pend[job]) begin
            o.rejected = 1'b1;
            if (m_count != COUNT_MAX) m_count = m_count + 1'b1;
            if (m_count > m_limit) m_fatal = 1'b1;
          end else if (m_fill < JOB_SPACE) begin
            m_pend[job] = 1'b1;
            m_stack[m_fill] = job;
            m_fill++;
            o.accepted = 1'b1;
          end
        end
        MODE_TAKE: begin
          if (m_fill > 0) begin
            m_fill--;
            o.job = m_stack[m_fill];
            m_pend[o.job] = 1'b0;
            o.popped = 1'b1;
          end
        end
        MODE_TICK: begin
          if (m_count != 0) begin
            if (m_last != m_count) begin
              m_last = m_count;
              m_age = '0;
            end else begin
              if (m_age != COUNT_MAX) m_age = m_age + 1'b1;
              if (m_age > m_window) begin
                m_count = '0;
                m_last = '0;
                m_age = '0;
              end
            end
          end
        end
        default: ;
      endcase
    end
    o.fatal = m_fatal;
    o.level = m_count;
    return o;
  endfunction

  task automatic queue_request(mode_e mode, logic [JOB_ID_W-1:0] job);
    request_t r;
    r.mode = mode;
    r.job = job;
    due_outcomes.push_back(predict_outcome(mode, job));
    job_requests.push_back(r);
  endtask

  function automatic logic [JOB_ID_W-1:0] any_job();
    return JOB_ID_W'($urandom_range(0, JOB_SPACE - 1));
  endfunction

  // Random traffic; unless fatal is allowed, a duplicate post that would push
  // the count over the limit is turned into a tick.
  task automatic queue_random(int n, int post_pct, bit allow_fatal);
    int r;
    mode_e mode;
    logic [JOB_ID_W-1:0] job;
    logic [LEVEL_W-1:0] bumped;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < post_pct) mode = MODE_POST;
      else if (r < post_pct + (100 - post_pct) / 2) mode = MODE_TAKE;
      else if (r < 97) mode = MODE_TICK;
      else mode = MODE_RSVD;
      job = ($urandom_range(0, 9) < 6) ? JOB_ID_W'($urandom_range(0, 7)) : any_job();
      if (mode == MODE_POST && m_pend[job] && !allow_fatal) begin
        bumped = (m_count == COUNT_MAX) ? m_count : m_count + 1'b1;
        if (bumped > m_limit) mode = MODE_TICK;
      end
      queue_request(mode, job);
    end
  endtask

  task automatic wait_drained();
    while (job_requests.size() != 0 || in_valid || due_outcomes.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_OVERLOAD_LIMIT) m_limit = val;
    else if (idx == CFG_QUIET_WINDOW) m_window = val;
  endtask

  // request driver
  always @(posedge clk_i) begin : drive_req
    request_t nxt;
    int gap_left;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (job_requests.size() > 0) begin
        nxt = job_requests.pop_front();
        in_valid <= 1'b1;
        in_mode  <= nxt.mode;
        in_job   <= nxt.job;
        gap_left = $urandom_range(0, gap_max);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk_i) begin : check_res
    outcome_t want;
    int stall_left;
    int seen;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        seen++;
        if (due_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: acc=%0b rej=%0b fatal=%0b pv=%0b job=%0d lvl=%0d",
                     accepted_o, rejected_busy_o, fatal_o, popped_valid_o,
                     popped_job_o, overload_level_o);
        end else begin
          want = due_outcomes.pop_front();
          if (accepted_o !== want.accepted || rejected_busy_o !== want.rejected ||
              fatal_o !== want.fatal || popped_valid_o !== want.popped ||
              popped_job_o !== want.job || overload_level_o !== want.level) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("mismatch at result %0d: exp acc=%0b rej=%0b fatal=%0b pv=%0b job=%0d lvl=%0d, got acc=%0b rej=%0b fatal=%0b pv=%0b job=%0d lvl=%0d",
                       seen, want.accepted, want.rejected, want.fatal, want.popped,
                       want.job, want.level, accepted_o, rejected_busy_o, fatal_o,
                       popped_valid_o, popped_job_o, overload_level_o);
          end
        end
        stall_left = (seen == HOLD_AT) ? HOLD_CYCLES : $urandom_range(0, stall_max);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_ready <= (stall_left == 0);
    end else begin
      stall_left = 0;
      seen = 0;
      out_ready <= 1'b0;
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin : watchdog
    int quiet;
    if (!rst_ni) begin
      quiet = 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int order[JOB_SPACE];
    int k, tmp, tail;
    for (int i = 0; i < JOB_SPACE; i++) begin
      m_pend[i] = 1'b0;
      m_stack[i] = '0;
    end
    m_fill = 0;
    m_count = '0;
    m_last = '0;
    m_age = '0;
    m_fatal = 1'b0;
    m_limit = LIMIT_RESET;
    m_window = WINDOW_RESET;
    while (!rst_ni) @(posedge clk_i);

    // directed: empty cases, bit patterns, duplicates, quiet-window clear
    queue_request(MODE_TICK, any_job());
    queue_request(MODE_TAKE, any_job());
    queue_request(MODE_RSVD, 6'd63);
    queue_request(MODE_POST, 6'd0);
    queue_request(MODE_POST, 6'd63);
    queue_request(MODE_POST, 6'd0);
    queue_request(MODE_POST, 6'd63);
    queue_request(MODE_TAKE, 6'd0);
    queue_request(MODE_TAKE, 6'd63);
    queue_request(MODE_TAKE, 6'd0);
    queue_request(MODE_POST, 6'd42);
    queue_request(MODE_POST, 6'd21);
    queue_request(MODE_POST, 6'd42);
    queue_request(MODE_RSVD, 6'd0);
    for (int i = 0; i < 7; i++) queue_request(MODE_TICK, any_job());
    queue_request(MODE_TICK, any_job());
    queue_request(MODE_TAKE, any_job());
    queue_request(MODE_TAKE, any_job());

    gap_max = 8;
    stall_max = 8;
    queue_random(250, 45, 1'b0);
    wait_drained();

    // shortest quiet window, full stack, no idling
    write_reg(CFG_OVERLOAD_LIMIT, 8'd254);
    write_reg(CFG_QUIET_WINDOW, 8'd0);
    gap_max = 0;
    stall_max = 0;
    for (int i = 0; i < JOB_SPACE; i++) order[i] = i;
    for (int i = JOB_SPACE - 1; i > 0; i--) begin
      k = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[k];
      order[k] = tmp;
    end
    for (int i = 0; i < JOB_SPACE; i++) queue_request(MODE_POST, JOB_ID_W'(order[i]));
    queue_request(MODE_POST, JOB_ID_W'(order[0]));
    for (int i = 0; i <= JOB_SPACE; i++) queue_request(MODE_TAKE, any_job());
    queue_random(100, 45, 1'b0);
    wait_drained();

    write_reg(CFG_OVERLOAD_LIMIT, 8'd0);
    write_reg(CFG_QUIET_WINDOW, 8'd254);
    gap_max = 8;
    stall_max = 0;
    queue_random(150, 45, 1'b0);
    wait_drained();

    write_reg(CFG_UNUSED2, CFG_W'($urandom_range(0, 255)));
    write_reg(CFG_OVERLOAD_LIMIT, CFG_W'($urandom_range(1, 253)));
    write_reg(CFG_QUIET_WINDOW, CFG_W'($urandom_range(1, 16)));
    gap_max = 2;
    stall_max = 8;
    queue_random(150, 45, 1'b0);
    wait_drained();

    // run the count to saturation and fatal, then check the frozen state
    write_reg(CFG_OVERLOAD_LIMIT, 8'd254);
    write_reg(CFG_QUIET_WINDOW, 8'd254);
    gap_max = 4;
    stall_max = 4;
    tail = 0;
    for (int i = 0; i < 3000 && tail < 60; i++) begin
      queue_random(1, 70, 1'b1);
      if (m_fatal) tail++;
    end
    wait_drained();
    repeat (20) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== dedup_job_stack_with_overload_watch_unit.f =====
design/djs_pkg.sv
design/djs_ram.sv
design/djs_watch.sv
design/djs_ctrl.sv
design/dedup_job_stack_with_overload_watch_unit.sv
design/djs_checker.sv
sim/tb.sv
